// ===== design/cgr_pkg.sv =====
package cgr_pkg;

  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam int GLYPH_DOTS = GLYPH_W * GLYPH_H;
  localparam int CHAR_GAP_DEF = 1;
  localparam logic [3:0] SCALE_RESET = 4'd1;
  localparam logic [31:0] COLOR_RESET = 32'hFFFF_FFFF;
  localparam logic [15:0] COORD_MAX = 16'hFFFF;

  localparam logic CFG_PIXEL_SCALE = 1'b0;
  localparam logic CFG_QUAD_COLOR = 1'b1;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        new_string;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } cgr_in_t;

  typedef struct packed {
    logic [15:0] quad_x;
    logic [15:0] quad_y;
    logic [3:0]  quad_size;
    logic [31:0] quad_rgba;
    logic        last_of_char;
  } cgr_out_t;

  typedef enum logic {
    CGR_IDLE,
    CGR_SCAN
  } cgr_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic advance;
  } cgr_cmd_t;

  typedef struct packed {
    logic bits_left;
    logic out_free;
  } cgr_sts_t;

  // Returns the 35 dots of a character, top row first, leftmost column as the
  // most significant bit. Codes without a glyph return all zeros.
  function automatic logic [GLYPH_DOTS-1:0] char_glyph(input logic [7:0] code);
    logic [7:0] c;
    logic [5:0] idx;
    logic       ok;
    logic [GLYPH_DOTS-1:0] g;
    c = code;
    ok = 1'b0;
    idx = '0;
    g = '0;
    if (c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    if (c >= 8'h41 && c <= 8'h5A) begin
      idx = 6'(c - 8'h41);
      ok = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      idx = 6'(c - 8'h30) + 6'd26;
      ok = 1'b1;
    end
    case (idx)
      6'd0:  g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd1:  g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      6'd2:  g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
      6'd3:  g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      6'd4:  g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      6'd5:  g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd6:  g = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      6'd7:  g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      6'd8:  g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      6'd9:  g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      6'd10: g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      6'd11: g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      6'd12: g = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      6'd13: g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      6'd14: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd15: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      6'd16: g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      6'd17: g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      6'd18: g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      6'd19: g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd20: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      6'd21: g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      6'd22: g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      6'd23: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      6'd24: g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      6'd25: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      6'd26: g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      6'd27: g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      6'd28: g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      6'd29: g = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      6'd30: g = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      6'd31: g = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      6'd32: g = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      6'd33: g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      6'd34: g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      6'd35: g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      default: g = '0;
    endcase
    return ok ? g : '0;
  endfunction

endpackage

// ===== design/char_glyph_rasterizer.sv =====
// Text rasterizer: turns characters into lit 5x7 dot squares.
// A request on the input channel carries one character code, a new-string
// flag and a string origin; the flag reloads the cursor and text row first.
// Lowercase letters draw as uppercase; only A-Z and 0-9 have glyphs.
// Every lit dot gives one result on the output channel: its top-left corner,
// edge size and color, with last_of_char set on the final square.
// The configuration channel is always ready and writes pixel_scale (index 0)
// or quad_color (index 1); it must be used only while the block is idle.
// A request is taken only when the scanner is idle. The glyph is scanned one
// dot per cycle from the top-left dot, and the scan stops after the last lit
// dot. After acceptance the scanner steps through the dots up to the last
// lit one, then advances the cursor, and only then takes the next request;
// a character without a glyph goes straight to the cursor advance. Each lit
// dot's square is registered in the output register as its dot is scanned.
// When the receiver stalls, the output register holds its square and the
// dot scan waits, so throughput is set by the receiver and the dot scan.
// Reset returns scale to 1, color to opaque white and the cursor and row to
// zero, and empties the output register.
module char_glyph_rasterizer
  import cgr_pkg::*;
#(
  parameter int CHAR_GAP = CHAR_GAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cgr_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cgr_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  cgr_cmd_t cmd;
  cgr_sts_t sts;

  assign cfg_ready = 1'b1;

  cgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cgr_dp #(
    .CHAR_GAP (CHAR_GAP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_write (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/cgr_ctrl.sv =====
module cgr_ctrl
  import cgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cgr_sts_t sts,
  output cgr_cmd_t cmd
);

  cgr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CGR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      CGR_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = CGR_SCAN;
        end
      end
      CGR_SCAN: begin
        if (!sts.bits_left) begin
          cmd.advance = 1'b1;
          state_next = CGR_IDLE;
        end else if (sts.out_free) begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = CGR_IDLE;
    endcase
  end

endmodule

// ===== design/cgr_dp.sv =====
module cgr_dp
  import cgr_pkg::*;
#(
  parameter int CHAR_GAP = CHAR_GAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cgr_in_t     in_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  cgr_cmd_t    cmd,
  output cgr_sts_t    sts,
  output logic        out_valid,
  input  logic        out_ready,
  output cgr_out_t    out_data
);

  localparam int Advance = GLYPH_W + CHAR_GAP;
  localparam int AdvW = $clog2(Advance * 15 + 1);

  logic [3:0]  pixel_scale;
  logic [31:0] quad_color;
  logic [15:0] cur_x;
  logic [15:0] text_row_y;
  logic [GLYPH_DOTS-1:0] glyph;
  logic [2:0]  col;
  logic [2:0]  row;

  logic [3:0]  scale;
  logic [6:0]  col_off;
  logic [6:0]  row_off;
  logic [16:0] x_sum;
  logic [16:0] y_sum;
  logic [AdvW-1:0] adv;
  logic [16:0] adv_sum;

  always_comb begin
    scale = (pixel_scale == 4'd0) ? 4'd1 : pixel_scale;
    col_off = 7'(col) * 7'(scale);
    row_off = 7'(row) * 7'(scale);
    x_sum = {1'b0, cur_x} + 17'(col_off);
    y_sum = {1'b0, text_row_y} + 17'(row_off);
    adv = AdvW'(Advance) * AdvW'(scale);
    adv_sum = {1'b0, cur_x} + 17'(adv);
    sts.bits_left = |glyph;
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_scale <= SCALE_RESET;
      quad_color <= COLOR_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_PIXEL_SCALE) begin
        pixel_scale <= cfg_data[3:0];
      end else begin
        quad_color <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      text_row_y <= '0;
      glyph <= '0;
      col <= '0;
      row <= '0;
    end else if (cmd.load) begin
      if (in_data.new_string) begin
        cur_x <= in_data.start_x;
        text_row_y <= in_data.start_y;
      end
      glyph <= char_glyph(in_data.char_code);
      col <= '0;
      row <= '0;
    end else if (cmd.step) begin
      glyph <= {glyph[GLYPH_DOTS-2:0], 1'b0};
      if (col == 3'(GLYPH_W - 1)) begin
        col <= '0;
        row <= row + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end else if (cmd.advance) begin
      cur_x <= adv_sum[16] ? COORD_MAX : adv_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && glyph[GLYPH_DOTS-1]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && glyph[GLYPH_DOTS-1]) begin
      out_data.quad_x <= x_sum[16] ? COORD_MAX : x_sum[15:0];
      out_data.quad_y <= y_sum[16] ? COORD_MAX : y_sum[15:0];
      out_data.quad_size <= scale;
      out_data.quad_rgba <= quad_color;
      out_data.last_of_char <= ~|glyph[GLYPH_DOTS-2:0];
    end
  end

endmodule

// ===== dv/tb_char_glyph_rasterizer.sv =====
`timescale 1ns / 100ps

module tb_char_glyph_rasterizer
  import cgr_pkg::*;
();

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 34;

  typedef struct packed {
    bit          cfg;
    logic [3:0]  scale;
    logic [31:0] color;
    logic [7:0]  code;
    logic        ns;
    logic [15:0] sx;
    logic [15:0] sy;
    int          dots;
    logic [15:0] fx;
    logic [15:0] fy;
  } plan_row_t;

  // A row with dots of -1 is checked only against the predictor.
  localparam plan_row_t PLAN [25] = '{
    '{1'b0, 4'd0,  32'h0,         8'h41, 1'b0, 16'h0000, 16'h0000, 18, 16'd1,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h61, 1'b0, 16'h0000, 16'h0000, 18, 16'd7,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h20, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h5A, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h7A, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h30, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h39, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h40, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h5B, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h60, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h7B, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h2F, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h3A, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h00, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'hFF, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'hC1, 1'b0, 16'h0000, 16'h0000, 0,  16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h48, 1'b1, 16'hFFFF, 16'hFFFF, 17, 16'hFFFF, 16'hFFFF},
    '{1'b0, 4'd0,  32'h0,         8'h38, 1'b1, 16'hFFF8, 16'h0010, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h57, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h4B, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b1, 4'd0,  32'h0,         8'h45, 1'b1, 16'd100,  16'd200,  18, 16'd100,  16'd200},
    '{1'b0, 4'd0,  32'h0,         8'h77, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b1, 4'd15, 32'h12345678,  8'h51, 1'b1, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h4D, 1'b0, 16'h0000, 16'h0000, -1, 16'd0,    16'd0},
    '{1'b0, 4'd0,  32'h0,         8'h34, 1'b1, 16'd65500, 16'd65500, -1, 16'd0,  16'd0}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  cgr_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  cgr_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  cgr_out_t    square_q [$];
  logic [3:0]  dot_scale = SCALE_RESET;
  logic [31:0] dot_color = COLOR_RESET;
  logic [15:0] pen_x = '0;
  logic [15:0] pen_y = '0;
  int          mismatches = 0;
  int          cycles = 0;
  bit          hold_request = 1'b0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  char_glyph_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic flag(input string msg);
    $display("ERROR at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic logic [15:0] clamp16(input int v);
    return (v > int'(COORD_MAX)) ? COORD_MAX : v[15:0];
  endfunction

  function automatic int glyph_slot(input logic [7:0] code);
    if (code >= "a" && code <= "z") return int'(code) - int'("a");
    if (code >= "A" && code <= "Z") return int'(code) - int'("A");
    if (code >= "0" && code <= "9") return int'(code) - int'("0") + 26;
    return -1;
  endfunction

  function automatic logic [34:0] glyph_bits(input int slot);
    case (slot)
      0:  return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      1:  return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      2:  return {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
      3:  return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
      4:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      5:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      6:  return {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
      7:  return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
      8:  return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      9:  return {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
      10: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      11: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      12: return {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      13: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      14: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      15: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      16: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
      17: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      18: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
      19: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      20: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      21: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
      22: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
      23: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
      24: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
      25: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
      26: return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
      27: return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      28: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
      29: return {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
      30: return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      31: return {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
      32: return {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
      33: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      34: return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
      35: return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
      default: return '0;
    endcase
  endfunction

  // Queues one square per lit dot of the request's character and moves the pen.
  task automatic draw_char(input cgr_in_t req, output int n, output cgr_out_t first);
    int          slot;
    int          step;
    int          row;
    int          col;
    logic [34:0] dots;
    cgr_out_t    sq;
    cgr_out_t    held;
    step = (dot_scale == 4'd0) ? 1 : int'(dot_scale);
    if (req.new_string) begin
      pen_x = req.start_x;
      pen_y = req.start_y;
    end
    slot = glyph_slot(req.char_code);
    dots = (slot < 0) ? '0 : glyph_bits(slot);
    n = 0;
    first = '0;
    held = '0;
    for (row = 0; row < GLYPH_H; row++) begin
      for (col = 0; col < GLYPH_W; col++) begin
        if (dots[GLYPH_DOTS - 1 - (row * GLYPH_W + col)]) begin
          sq.quad_x = clamp16(int'(pen_x) + col * step);
          sq.quad_y = clamp16(int'(pen_y) + row * step);
          sq.quad_size = step[3:0];
          sq.quad_rgba = dot_color;
          sq.last_of_char = 1'b0;
          if (n > 0) square_q.insert(square_q.size(), held);
          else first = sq;
          held = sq;
          n++;
        end
      end
    end
    if (n > 0) begin
      held.last_of_char = 1'b1;
      square_q.insert(square_q.size(), held);
    end
    pen_x = clamp16(int'(pen_x) + (GLYPH_W + CHAR_GAP_DEF) * step);
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!send_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [15:0] rand_origin();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 2000));
      1: return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cgr_in_t rand_request();
    cgr_in_t req;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 45) req.char_code = 8'("A" + $urandom_range(0, 25));
    else if (r < 65) req.char_code = 8'("a" + $urandom_range(0, 25));
    else if (r < 80) req.char_code = 8'("0" + $urandom_range(0, 9));
    else req.char_code = 8'($urandom_range(0, 255));
    req.new_string = ($urandom_range(0, 99) < 15);
    req.start_x = rand_origin();
    req.start_y = rand_origin();
    return req;
  endfunction

  task automatic send_request(input cgr_in_t req, input int gap, input int dots,
                              input logic [15:0] fx, input logic [15:0] fy);
    int       n;
    cgr_out_t first;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    draw_char(req, n, first);
    if (dots >= 0 && (n != dots || (n > 0 && (first.quad_x != fx || first.quad_y != fy))))
      flag($sformatf("code %02h: %0d squares from (%0d,%0d), table gives %0d from (%0d,%0d)",
                     req.char_code, n, first.quad_x, first.quad_y, dots, fx, fy));
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_PIXEL_SCALE) dot_scale = val[3:0];
    else dot_color = val;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (square_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cgr_in_t     req;
    logic [3:0]  scale;
    logic [31:0] color;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PIXEL_SCALE;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (PLAN[i]) begin
      if (PLAN[i].cfg) begin
        settle();
        write_reg(CFG_PIXEL_SCALE, {28'd0, PLAN[i].scale});
        write_reg(CFG_QUAD_COLOR, PLAN[i].color);
      end
      req.char_code = PLAN[i].code;
      req.new_string = PLAN[i].ns;
      req.start_x = PLAN[i].sx;
      req.start_y = PLAN[i].sy;
      send_request(req, next_gap(), PLAN[i].dots, PLAN[i].fx, PLAN[i].fy);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          scale = 4'd15;
          color = 32'h0000_0000;
        end
        1: begin
          scale = 4'd1;
          color = 32'hFFFF_FFFF;
        end
        2: begin
          scale = 4'd0;
          color = $urandom;
        end
        default: begin
          scale = 4'($urandom_range(0, 15));
          color = $urandom;
        end
      endcase
      write_reg(CFG_PIXEL_SCALE, {28'd0, scale});
      write_reg(CFG_QUAD_COLOR, color);
      send_idle = (p != 4);
      recv_idle = (p != 5);
      hold_request = (p == 3);
      for (int i = 0; i < PHASE_REQUESTS; i++)
        send_request(rand_request(), next_gap(), -1, '0, '0);
    end

    settle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    int r;
    int n;
    out_ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (!recv_idle || r < 60) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 8);
        end else begin
          out_ready <= 1'b0;
          n = (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cgr_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (square_q.size() == 0) begin
        flag($sformatf("square (%0d,%0d) with none pending", out_data.quad_x, out_data.quad_y));
      end else begin
        want = square_q.pop_front();
        if (out_data.quad_x !== want.quad_x)
          flag($sformatf("quad_x %0d, want %0d", out_data.quad_x, want.quad_x));
        if (out_data.quad_y !== want.quad_y)
          flag($sformatf("quad_y %0d, want %0d", out_data.quad_y, want.quad_y));
        if (out_data.quad_size !== want.quad_size)
          flag($sformatf("quad_size %0d, want %0d", out_data.quad_size, want.quad_size));
        if (out_data.quad_rgba !== want.quad_rgba)
          flag($sformatf("quad_rgba %08h, want %08h", out_data.quad_rgba, want.quad_rgba));
        if (out_data.last_of_char !== want.last_of_char)
          flag($sformatf("last_of_char %b, want %b at (%0d,%0d)",
                         out_data.last_of_char, want.last_of_char, want.quad_x, want.quad_y));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
